### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### design/tsct_pkg.sv
// Types, constants and widths shared by the Taylor sine, cosine and tangent unit.
package tsct_pkg;

   localparam int TERMS_DEF     = 10;
   localparam int FRAC_BITS_DEF = 28;
   localparam int ANGLE_W       = 32;
   localparam int VALUE_W       = 48;
   localparam int MAG_W         = 62;
   localparam int SUM_W         = 63;
   localparam int TERM_LAT      = 7;
   localparam int QUO_W         = 50;
   localparam int DIV_BITS      = 2;
   localparam int DIV_STAGES    = QUO_W / DIV_BITS;

   localparam logic [MAG_W-1:0]        MAG_LIM     = '1;
   localparam logic signed [SUM_W-1:0] SUM_LIM     = 63'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_OUT_MAX = 63'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_OUT_MIN = 63'sh7FFF_8000_0000_0000;
   localparam logic [VALUE_W-1:0]      VALUE_MAX   = 48'h7FFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0]      VALUE_MIN   = 48'h8000_0000_0000;

   typedef enum logic [1:0] {
      CMD_SINE    = 2'd0,
      CMD_COSINE  = 2'd1,
      CMD_TANGENT = 2'd2
   } command_type;

   typedef struct packed {
      command_type               command;
      logic signed [ANGLE_W-1:0] angle;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      saturated;
   } rsp_type;

   typedef struct packed {
      logic [MAG_W-1:0]        mag;
      logic                    neg;
      logic signed [SUM_W-1:0] sum;
      logic                    ovf;
   } series_type;

   typedef struct packed {
      logic        valid;
      command_type command;
   } ctl_type;

   typedef struct packed {
      logic                valid;
      command_type         command;
      logic [VALUE_W-1:0]  direct_value;
      logic                direct_sat;
      logic                quo_neg;
      logic                tan_ovf;
   } div_tag_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] lo;
      logic [QUO_W-1:0] quo;
      logic [MAG_W-1:0] cm;
   } div_work_type;

endpackage

### design/tsct_mul.sv
// Two-stage unsigned multiplier built from four registered partial products.
module tsct_mul #(
   parameter int AW = 62,
   parameter int BW = 36
) (
   input  logic             clock,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] product
);

   localparam int AL = (AW + 1) / 2;
   localparam int AH = AW - AL;
   localparam int BL = (BW + 1) / 2;
   localparam int BH = BW - BL;
   localparam int PW = AW + BW;

   logic [AL+BL-1:0] pp_ll_in, pp_ll_ff;
   logic [AL+BH-1:0] pp_lh_in, pp_lh_ff;
   logic [AH+BL-1:0] pp_hl_in, pp_hl_ff;
   logic [AH+BH-1:0] pp_hh_in, pp_hh_ff;
   logic [PW-1:0]    product_in, product_ff;

   always_comb begin
      pp_ll_in   = a[AL-1:0] * b[BL-1:0];
      pp_lh_in   = a[AL-1:0] * b[BW-1:BL];
      pp_hl_in   = a[AW-1:AL] * b[BL-1:0];
      pp_hh_in   = a[AW-1:AL] * b[BW-1:BL];
      product_in = PW'(pp_ll_ff) + (PW'(pp_lh_ff) << BL) + (PW'(pp_hl_ff) << AL)
                 + (PW'(pp_hh_ff) << (AL + BL));
   end

   always_ff @(posedge clock) begin
      pp_ll_ff   <= pp_ll_in;
      pp_lh_ff   <= pp_lh_in;
      pp_hl_ff   <= pp_hl_in;
      pp_hh_ff   <= pp_hh_in;
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### design/tsct_term.sv
// One pipelined series term: accumulate the term, then form the next one.
module tsct_term #(
   parameter int FRAC_BITS = tsct_pkg::FRAC_BITS_DEF,
   parameter int DIVISOR   = 6
) (
   input  logic                      clock,
   input  tsct_pkg::series_type      src,
   input  logic [63-FRAC_BITS:0]     src_x2,
   output tsct_pkg::series_type      dst,
   output logic [63-FRAC_BITS:0]     dst_x2
);

   localparam int X2W   = 64 - FRAC_BITS;
   localparam int MW    = tsct_pkg::MAG_W;
   localparam int SW    = tsct_pkg::SUM_W;
   localparam int LAT   = tsct_pkg::TERM_LAT;
   localparam logic [63:0]   RECIP  = 64'h8000_0000_0000_0000 / 64'(DIVISOR);
   localparam logic [MW:0]   HALF_D = (MW + 1)'(DIVISOR / 2);
   localparam logic [MW:0]   DIV_W  = (MW + 1)'(DIVISOR);
   localparam logic signed [SW:0] WIDE_LIM = (SW + 1)'(tsct_pkg::SUM_LIM);

   logic signed [SW:0]   step_val;
   logic signed [SW:0]   wide_sum;
   logic signed [SW-1:0] sum_in;
   logic                 sovf_in;
   logic [MW+X2W-1:0]    prod1;
   logic [127:0]         rnd;
   logic                 p_ovf;
   logic [MW-1:0]        p_in, p_ff;
   logic [MW:0]          n_in, n_ff, n_d1_ff, n_d2_ff;
   logic [MW+64:0]       prod2;
   logic [MW:0]          quot_est;
   logic [MW:0]          resid;
   logic [MW:0]          q_in;
   logic [MW-1:0]        q_ff;

   logic signed [SW-1:0] sum_pipe_ff [LAT];
   logic                 ovf_pipe_ff [LAT];
   logic                 neg_pipe_ff [LAT];
   logic [X2W-1:0]       x2_pipe_ff  [LAT];

   tsct_mul #(.AW(MW), .BW(X2W)) u_mul_sq (
      .clock   (clock),
      .a       (src.mag),
      .b       (src_x2),
      .product (prod1)
   );

   tsct_mul #(.AW(MW + 1), .BW(64)) u_mul_recip (
      .clock   (clock),
      .a       (n_ff),
      .b       (RECIP),
      .product (prod2)
   );

   always_comb begin
      step_val = src.neg ? -$signed({2'b00, src.mag}) : $signed({2'b00, src.mag});
      wide_sum = $signed({src.sum[SW-1], src.sum}) + step_val;
      sovf_in  = src.ovf;
      if (wide_sum > WIDE_LIM) begin
         sum_in  = tsct_pkg::SUM_LIM;
         sovf_in = 1'b1;
      end else if (wide_sum < -WIDE_LIM) begin
         sum_in  = -tsct_pkg::SUM_LIM;
         sovf_in = 1'b1;
      end else begin
         sum_in = wide_sum[SW-1:0];
      end
      rnd      = 128'(prod1) + (128'(1) << (FRAC_BITS - 1));
      p_ovf    = |rnd[127:MW+FRAC_BITS];
      p_in     = p_ovf ? tsct_pkg::MAG_LIM : rnd[MW+FRAC_BITS-1:FRAC_BITS];
      n_in     = {1'b0, p_ff} + HALF_D;
      quot_est = prod2[2*MW+1:MW+1];
      resid    = n_d2_ff - (MW + 1)'(quot_est * DIV_W);
      q_in     = (resid >= DIV_W) ? quot_est + 1'b1 : quot_est;
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      n_ff    <= n_in;
      n_d1_ff <= n_ff;
      n_d2_ff <= n_d1_ff;
      q_ff    <= q_in[MW-1:0];
      sum_pipe_ff[0] <= sum_in;
      ovf_pipe_ff[0] <= sovf_in;
      neg_pipe_ff[0] <= src.neg;
      x2_pipe_ff[0]  <= src_x2;
      for (int i = 1; i < LAT; i++) begin
         sum_pipe_ff[i] <= sum_pipe_ff[i-1];
         ovf_pipe_ff[i] <= (i == 2) ? (ovf_pipe_ff[i-1] | p_ovf) : ovf_pipe_ff[i-1];
         neg_pipe_ff[i] <= neg_pipe_ff[i-1];
         x2_pipe_ff[i]  <= x2_pipe_ff[i-1];
      end
   end

   always_comb begin
      dst.mag = q_ff;
      dst.neg = ~neg_pipe_ff[LAT-1];
      dst.sum = sum_pipe_ff[LAT-1];
      dst.ovf = ovf_pipe_ff[LAT-1];
      dst_x2  = x2_pipe_ff[LAT-1];
   end

endmodule

### design/tsct_div.sv
// Pipelined restoring divider for the tangent quotient, two bits per stage.
module tsct_div (
   input  logic                   clock,
   input  logic                   reset,
   input  tsct_pkg::div_work_type src_work,
   input  tsct_pkg::div_tag_type  src_tag,
   output tsct_pkg::div_work_type dst_work,
   output tsct_pkg::div_tag_type  dst_tag
);

   localparam int NS = tsct_pkg::DIV_STAGES;
   localparam int MW = tsct_pkg::MAG_W;
   localparam int QW = tsct_pkg::QUO_W;

   tsct_pkg::div_work_type work_in [NS];
   tsct_pkg::div_work_type work_ff [NS];
   tsct_pkg::div_tag_type  tag_ff  [NS];

   always_comb begin
      tsct_pkg::div_work_type cur;
      logic [MW:0]            shifted;
      for (int s = 0; s < NS; s++) begin
         cur = (s == 0) ? src_work : work_ff[s-1];
         for (int b = 0; b < tsct_pkg::DIV_BITS; b++) begin
            shifted = {cur.rem, cur.lo[QW-1]};
            cur.lo  = cur.lo << 1;
            if (shifted >= {1'b0, cur.cm}) begin
               shifted = shifted - {1'b0, cur.cm};
               cur.quo = {cur.quo[QW-2:0], 1'b1};
            end else begin
               cur.quo = {cur.quo[QW-2:0], 1'b0};
            end
            cur.rem = shifted[MW-1:0];
         end
         work_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         work_ff[s] <= work_in[s];
         tag_ff[s]  <= (s == 0) ? src_tag : tag_ff[s-1];
      end
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            tag_ff[s].valid <= 1'b0;
         end
      end
   end

   assign dst_work = work_ff[NS-1];
   assign dst_tag  = tag_ff[NS-1];

endmodule

### design/taylor_sine_cosine_tangent_unit.sv
// Top level of the pipelined Taylor series sine, cosine and tangent unit.
// One request can be taken in every cycle while reset is low; throughput is set by the fully unrolled term pipeline.
// Each series term takes seven stages (two split multiplies); the tangent divider takes 25 stages.
// Reset clears all valid bits; busy is high only while reset is held.
`include "assert_macros.svh"
module taylor_sine_cosine_tangent_unit #(
   parameter int TERMS     = tsct_pkg::TERMS_DEF,
   parameter int FRAC_BITS = tsct_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tsct_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tsct_pkg::rsp_type rsp_data
);

   localparam int X2W     = 64 - FRAC_BITS;
   localparam int AW      = tsct_pkg::ANGLE_W;
   localparam int MW      = tsct_pkg::MAG_W;
   localparam int SW      = tsct_pkg::SUM_W;
   localparam int QW      = tsct_pkg::QUO_W;
   localparam int VW      = tsct_pkg::VALUE_W;
   localparam int HW      = 128 - QW;
   localparam int CTL_LEN = 3 + TERMS * tsct_pkg::TERM_LAT;
   localparam int RSP_LAT = CTL_LEN + 4 + tsct_pkg::DIV_STAGES;

   logic                   accept;
   tsct_pkg::req_type      req_ff;
   logic                   req_valid_ff;
   logic [AW-1:0]          xmag_in, xmag_ff, xmag2_ff;
   logic                   xneg_ff, xneg2_ff;
   logic [63:0]            sq_ff;
   logic [63:0]            sq_rnd;
   logic [X2W-1:0]         x2_ff;
   tsct_pkg::series_type   sin0_in, sin0_ff, cos0_in, cos0_ff;
   tsct_pkg::ctl_type      ctl_ff [CTL_LEN];

   tsct_pkg::series_type   sin_chain [TERMS+1];
   tsct_pkg::series_type   cos_chain [TERMS+1];
   logic [X2W-1:0]         x2_chain  [TERMS+1];

   tsct_pkg::series_type   pick;
   tsct_pkg::series_type   sin_end, cos_end;
   tsct_pkg::div_tag_type  e1_tag_in, e1_tag_ff, e2_tag_in, e2_tag_ff;
   logic [MW-1:0]          sm_in, sm_ff, cm_in, cm_ff;
   logic [127:0]           nvec;
   tsct_pkg::div_work_type e2_work_in, e2_work_ff;
   tsct_pkg::div_work_type dw;
   tsct_pkg::div_tag_type  dt;
   logic                   rnd_up;
   logic [QW:0]            qr;
   logic                   tan_sat;
   logic [VW-1:0]          tan_val;
   tsct_pkg::rsp_type      rsp_in, rsp_ff;
   logic                   strobe_in, strobe_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      xmag_in = req_ff.angle[AW-1] ? AW'(-req_ff.angle) : AW'(req_ff.angle);
      sq_rnd  = sq_ff + (64'(1) << (FRAC_BITS - 1));
      sin0_in.mag = MW'(xmag2_ff);
      sin0_in.neg = xneg2_ff;
      sin0_in.sum = '0;
      sin0_in.ovf = 1'b0;
      cos0_in.mag = MW'(1) << FRAC_BITS;
      cos0_in.neg = 1'b0;
      cos0_in.sum = '0;
      cos0_in.ovf = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      xmag_ff  <= xmag_in;
      xneg_ff  <= req_ff.angle[AW-1];
      sq_ff    <= xmag_ff * xmag_ff;
      xmag2_ff <= xmag_ff;
      xneg2_ff <= xneg_ff;
      x2_ff    <= sq_rnd[63:FRAC_BITS];
      sin0_ff  <= sin0_in;
      cos0_ff  <= cos0_in;
      ctl_ff[0].valid   <= req_valid_ff;
      ctl_ff[0].command <= req_ff.command;
      for (int i = 1; i < CTL_LEN; i++) begin
         ctl_ff[i] <= ctl_ff[i-1];
      end
      if (reset) begin
         req_valid_ff <= 1'b0;
         for (int i = 0; i < CTL_LEN; i++) begin
            ctl_ff[i].valid <= 1'b0;
         end
      end else begin
         req_valid_ff <= accept;
      end
   end

   assign sin_chain[0] = sin0_ff;
   assign cos_chain[0] = cos0_ff;
   assign x2_chain[0]  = x2_ff;

   for (genvar n = 0; n < TERMS; n++) begin : g_term
      tsct_term #(
         .FRAC_BITS (FRAC_BITS),
         .DIVISOR   ((2 * n + 2) * (2 * n + 3))
      ) u_sine (
         .clock  (clock),
         .src    (sin_chain[n]),
         .src_x2 (x2_chain[n]),
         .dst    (sin_chain[n+1]),
         .dst_x2 (x2_chain[n+1])
      );
      tsct_term #(
         .FRAC_BITS (FRAC_BITS),
         .DIVISOR   ((2 * n + 1) * (2 * n + 2))
      ) u_cosine (
         .clock  (clock),
         .src    (cos_chain[n]),
         .src_x2 (x2_chain[n]),
         .dst    (cos_chain[n+1]),
         .dst_x2 ()
      );
   end

   always_comb begin
      sin_end = sin_chain[TERMS];
      cos_end = cos_chain[TERMS];
      pick    = (ctl_ff[CTL_LEN-1].command == tsct_pkg::CMD_COSINE) ? cos_end : sin_end;
      e1_tag_in.valid   = ctl_ff[CTL_LEN-1].valid;
      e1_tag_in.command = ctl_ff[CTL_LEN-1].command;
      if (pick.ovf || pick.sum > tsct_pkg::SUM_OUT_MAX || pick.sum < tsct_pkg::SUM_OUT_MIN) begin
         e1_tag_in.direct_sat   = 1'b1;
         e1_tag_in.direct_value = pick.sum[SW-1] ? tsct_pkg::VALUE_MIN : tsct_pkg::VALUE_MAX;
      end else begin
         e1_tag_in.direct_sat   = 1'b0;
         e1_tag_in.direct_value = pick.sum[VW-1:0];
      end
      e1_tag_in.quo_neg = sin_end.sum[SW-1] ^ cos_end.sum[SW-1];
      e1_tag_in.tan_ovf = sin_end.ovf | cos_end.ovf;
      sm_in = sin_end.sum[SW-1] ? MW'(-sin_end.sum) : MW'(sin_end.sum);
      cm_in = cos_end.sum[SW-1] ? MW'(-cos_end.sum) : MW'(cos_end.sum);

      nvec      = 128'(sm_ff) << FRAC_BITS;
      e2_tag_in = e1_tag_ff;
      e2_tag_in.tan_ovf = e1_tag_ff.tan_ovf || (nvec[127:QW] >= HW'(cm_ff));
      e2_work_in.rem = e2_tag_in.tan_ovf ? '0 : nvec[QW+MW-1:QW];
      e2_work_in.lo  = nvec[QW-1:0];
      e2_work_in.quo = '0;
      e2_work_in.cm  = cm_ff;
   end

   always_ff @(posedge clock) begin
      e1_tag_ff  <= e1_tag_in;
      sm_ff      <= sm_in;
      cm_ff      <= cm_in;
      e2_tag_ff  <= e2_tag_in;
      e2_work_ff <= e2_work_in;
      if (reset) begin
         e1_tag_ff.valid <= 1'b0;
         e2_tag_ff.valid <= 1'b0;
      end
   end

   tsct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .src_work (e2_work_ff),
      .src_tag  (e2_tag_ff),
      .dst_work (dw),
      .dst_tag  (dt)
   );

   always_comb begin
      rnd_up  = dw.rem >= (dw.cm - dw.rem);
      qr      = (QW + 1)'(dw.quo) + (QW + 1)'(rnd_up);
      tan_sat = dt.tan_ovf
             || (!dt.quo_neg && qr > (QW + 1)'(tsct_pkg::VALUE_MAX))
             || (dt.quo_neg && qr > (QW + 1)'(tsct_pkg::VALUE_MAX) + 1'b1);
      if (tan_sat) begin
         tan_val = tsct_pkg::VALUE_MAX;
      end else begin
         tan_val = dt.quo_neg ? VW'(-qr) : VW'(qr);
      end
      case (dt.command)
         tsct_pkg::CMD_SINE, tsct_pkg::CMD_COSINE: begin
            rsp_in.value     = dt.direct_value;
            rsp_in.saturated = dt.direct_sat;
         end
         tsct_pkg::CMD_TANGENT: begin
            rsp_in.value     = tan_val;
            rsp_in.saturated = tan_sat;
         end
         default: begin
            rsp_in.value     = '0;
            rsp_in.saturated = 1'b0;
         end
      endcase
      strobe_in = dt.valid;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `ASSERT_PROP(a_every_transfer_answered, clock, reset, $past(start && !busy, RSP_LAT) |-> rsp_strobe)
   `ASSERT_PROP(a_no_unrequested_result, clock, reset, rsp_strobe |-> $past(start && !busy, RSP_LAT))
   `ASSERT_PROP(a_sat_value_is_limit, clock, reset, (rsp_strobe && rsp_data.saturated) |-> (rsp_data.value == tsct_pkg::VALUE_MAX || rsp_data.value == tsct_pkg::VALUE_MIN))
   `ASSERT_PROP(a_unused_cmd_zero, clock, reset, $past(start && !busy && req_data.command != tsct_pkg::CMD_SINE && req_data.command != tsct_pkg::CMD_COSINE && req_data.command != tsct_pkg::CMD_TANGENT, RSP_LAT) |-> (rsp_data.value == '0 && !rsp_data.saturated))

endmodule

### bench/taylor_sine_cosine_tangent_unit_tb.sv
// Testbench for the Taylor series sine, cosine and tangent unit with a built-in predictor.
`timescale 1ns / 1ps
module taylor_sine_cosine_tangent_unit_tb;

   localparam int FRAC = tsct_pkg::FRAC_BITS_DEF;
   localparam int NTERMS = tsct_pkg::TERMS_DEF;
   localparam int LATENCY = 31 + 7 * NTERMS;
   localparam int AW = tsct_pkg::ANGLE_W;
   localparam int VW = tsct_pkg::VALUE_W;
   localparam logic [63:0] HOLD_LIM = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam longint VAL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tsct_pkg::req_type req_data = '0;
   logic rsp_strobe;
   tsct_pkg::rsp_type rsp_data;

   tsct_pkg::req_type pending_q[$];
   tsct_pkg::rsp_type expected_q[$];
   int mismatches = 0;
   bit stim_done = 1'b0;
   bit hold_off = 1'b0;
   int quiet_from = 0;
   int quiet_to = 0;
   int sent = 0;

   taylor_sine_cosine_tangent_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b,
                                                  ref bit ovf);
      logic [127:0] p;
      p = 128'(a) * 128'(b) + (128'd1 << (FRAC - 1));
      p = p >> FRAC;
      if (p > 128'(HOLD_LIM)) begin
         ovf = 1'b1;
         return HOLD_LIM;
      end
      return p[63:0];
   endfunction

   function automatic longint taylor_sum(bit cosine, logic [63:0] xmag, bit xneg,
                                         logic [63:0] x2, ref bit ovf);
      logic [63:0] mag;
      logic [63:0] d;
      logic [63:0] p;
      bit neg;
      longint sum;
      mag = cosine ? (64'd1 << FRAC) : xmag;
      neg = cosine ? 1'b0 : xneg;
      sum = 0;
      for (int n = 0; n < NTERMS; n++) begin
         sum += neg ? -longint'(mag) : longint'(mag);
         if (sum > longint'(HOLD_LIM)) begin
            sum = longint'(HOLD_LIM);
            ovf = 1'b1;
         end else if (sum < -longint'(HOLD_LIM)) begin
            sum = -longint'(HOLD_LIM);
            ovf = 1'b1;
         end
         d = 2 * n + (cosine ? 1 : 2);
         d = d * (d + 1);
         p = scaled_product(mag, x2, ovf);
         mag = (p + d / 2) / d;
         neg = !neg;
      end
      return sum;
   endfunction

   function automatic tsct_pkg::rsp_type trig_result(tsct_pkg::req_type item);
      tsct_pkg::rsp_type r;
      logic [63:0] xmag, x2, sm, cm;
      logic [127:0] num, q, rem;
      bit xneg, ovf, qneg;
      longint s, c, v;
      r = '0;
      ovf = 1'b0;
      xneg = item.angle[AW-1];
      xmag = xneg ? 64'(-longint'(item.angle)) : 64'(item.angle);
      x2 = (xmag * xmag + (64'd1 << (FRAC - 1))) >> FRAC;
      if (item.command == tsct_pkg::CMD_SINE || item.command == tsct_pkg::CMD_COSINE) begin
         s = taylor_sum(item.command == tsct_pkg::CMD_COSINE, xmag, xneg, x2, ovf);
         if (ovf || s > VAL_MAX || s < -VAL_MAX - 1) begin
            r.saturated = 1'b1;
            v = (s < 0) ? -VAL_MAX - 1 : VAL_MAX;
         end else begin
            v = s;
         end
         r.value = v[VW-1:0];
      end else if (item.command == tsct_pkg::CMD_TANGENT) begin
         s = taylor_sum(1'b0, xmag, xneg, x2, ovf);
         c = taylor_sum(1'b1, xmag, xneg, x2, ovf);
         if (ovf || c == 0) begin
            r.saturated = 1'b1;
            r.value = tsct_pkg::VALUE_MAX;
         end else begin
            sm = (s < 0) ? 64'(-s) : 64'(s);
            cm = (c < 0) ? 64'(-c) : 64'(c);
            qneg = (s < 0) != (c < 0);
            num = 128'(sm) << FRAC;
            q = num / 128'(cm);
            rem = num % 128'(cm);
            if (2 * rem >= 128'(cm)) q = q + 1;
            if ((!qneg && q > 128'(VAL_MAX)) || (qneg && q > 128'(VAL_MAX) + 1)) begin
               r.saturated = 1'b1;
               r.value = tsct_pkg::VALUE_MAX;
            end else begin
               v = qneg ? -longint'(q[63:0]) : longint'(q[63:0]);
               r.value = v[VW-1:0];
            end
         end
      end
      return r;
   endfunction

   function automatic logic signed [AW-1:0] random_angle();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return AW'($signed($urandom_range(0, 32'h3000_0000)) *
                    ($urandom_range(0, 1) ? 1 : -1));
         2: return AW'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
         3: return AW'($signed($urandom_range(0, 32'h7000_0000)) - 32'sh3800_0000);
         default: return AW'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_q.push_back(trig_result(req_data));
            pending_q.pop_front();
            sent++;
         end
         if (pending_q.size() > 0 && !hold_off &&
             ((sent >= quiet_from && sent < quiet_to) || $urandom_range(0, 99) >= 35)) begin
            start <= 1'b1;
            req_data <= pending_q[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result value=%h", rsp_data.value);
         end else begin
            if (rsp_data !== expected_q[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected value=%h sat=%b, actual value=%h sat=%b",
                           expected_q[0].value, expected_q[0].saturated,
                           rsp_data.value, rsp_data.saturated);
            end
            void'(expected_q.pop_front());
         end
      end
   end

   task automatic add_item(logic [1:0] cmd, logic signed [AW-1:0] ang);
      tsct_pkg::req_type item;
      item.command = tsct_pkg::command_type'(cmd);
      item.angle = ang;
      pending_q.push_back(item);
   endtask

   initial begin
      logic signed [AW-1:0] angles[9];
      logic [1:0] cmd;
      angles = '{32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1000_0000,
                 32'shF000_0000, 32'sh1921_FB54, 32'sh0000_0001, 32'shFFFF_FFFF,
                 32'sh3243_F6A9};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 9; i++) begin
         add_item(tsct_pkg::CMD_SINE, angles[i]);
         add_item(tsct_pkg::CMD_COSINE, angles[i]);
      end
      add_item(tsct_pkg::CMD_TANGENT, 32'sh1921_FB54);
      add_item(tsct_pkg::CMD_TANGENT, 32'sh7FFF_FFFF);
      add_item(tsct_pkg::CMD_TANGENT, 32'shE6DE_04AC);
      add_item(tsct_pkg::CMD_TANGENT, 32'sh0000_0000);
      add_item(CMD_UNUSED, 32'sh1234_5678);
      wait (pending_q.size() == 0);
      hold_off = 1'b1;
      wait (expected_q.size() == 0);
      hold_off = 1'b0;
      quiet_from = 200;
      quiet_to = 400;
      for (int i = 0; i < 1400; i++) begin
         cmd = ($urandom_range(0, 29) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
         add_item(cmd, random_angle());
      end
      wait (pending_q.size() == 0);
      wait (expected_q.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
